>>> hdl/whcp_pkg.sv
// ----------------------------------------------------------------------------
// WAV header chunk parser package
// Shared constants, codes, structs and character lookups.
// ----------------------------------------------------------------------------
package whcp_pkg;

	localparam int FMT_BYTES = 16;
	localparam int FMT_IDX_W = $clog2(FMT_BYTES);
	localparam int FMT_CNT_W = $clog2(FMT_BYTES + 1);

	localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
	localparam logic [31:0] TAG_DATA = 32'h6174_6164;

	localparam int OUT_TDATA_W = 200;

	typedef enum logic [2:0] {
		PH_RIFF,
		PH_CHUNK_HDR,
		PH_BODY,
		PH_PAD,
		PH_DONE
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_INVALID     = 2'd1,
		ST_UNSUPPORTED = 2'd2
	} status_t;

	typedef struct packed {
		logic                 en;
		logic                 clr;
		logic [FMT_IDX_W-1:0] idx;
		logic [7:0]           data;
	} fmt_wr_t;

	typedef struct packed {
		logic [15:0] fmt_code;
		logic [15:0] chan_count;
		logic [31:0] samp_rate;
		logic [31:0] byte_rate;
		logic [15:0] block_align;
		logic [15:0] samp_bits;
	} fmt_fields_t;

	typedef struct packed {
		status_t     status;
		logic [31:0] payload_pos;
		logic [31:0] payload_len;
		fmt_fields_t fmt;
	} res_t;

	function automatic logic [7:0] riff_char(input logic [1:0] k);
		logic [7:0] c;
		case (k)
			2'd0: c = 8'h52;
			2'd1: c = 8'h49;
			2'd2: c = 8'h46;
			default: c = 8'h46;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] wave_char(input logic [1:0] k);
		logic [7:0] c;
		case (k)
			2'd0: c = 8'h57;
			2'd1: c = 8'h41;
			2'd2: c = 8'h56;
			default: c = 8'h45;
		endcase
		return c;
	endfunction

endpackage

>>> hdl/wav_header_chunk_parser.sv
// ----------------------------------------------------------------------------
// WAV header chunk parser
// Walks a RIFF/WAVE byte stream and reports the first data chunk and format.
// ----------------------------------------------------------------------------
// channel   dir  tdata                                   side
// s_axis    in   byte_value[7:0]                         tlast = last_byte
// m_axis    out  status..samp_bits, 194 bits used        none
//
// One byte is taken every cycle while s_axis_tready is high; the per-byte state update is the only loop.
// A result is registered in the output stage (skid entry first under stall) before it appears on m_axis.
// s_axis_tready falls only when a result is held and a second one is parked.
// Reset clears all parse state; the last byte of a file returns it to reset.
// ----------------------------------------------------------------------------
module wav_header_chunk_parser (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [7:0]   s_axis_tdata,   // byte_value
	input  logic         s_axis_tlast,   // last_byte
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// status[1:0], payload_pos[33:2], payload_len[65:34], fmt_code[81:66],
	// chan_count[97:82], samp_rate[129:98], byte_rate[161:130],
	// block_align[177:162], samp_bits[193:178], zero fill above
	output logic [whcp_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

	logic                  take;
	logic                  res_valid;
	whcp_pkg::res_t        res;
	whcp_pkg::res_t        out_res;
	whcp_pkg::fmt_wr_t     fmt_wr;
	whcp_pkg::fmt_fields_t fmt_fields;

	assign take = s_axis_tvalid && s_axis_tready;

	whcp_fmt u_fmt (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (fmt_wr),
		.fields (fmt_fields)
	);

	whcp_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.byte_value (s_axis_tdata),
		.last_byte  (s_axis_tlast),
		.fmt        (fmt_fields),
		.res_valid  (res_valid),
		.res        (res),
		.fmt_wr     (fmt_wr)
	);

	whcp_skid u_skid (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (res_valid),
		.push_data  (res),
		.push_ready (s_axis_tready),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_data   (out_res)
	);

	assign m_axis_tdata = {6'd0,
		out_res.fmt.samp_bits,
		out_res.fmt.block_align,
		out_res.fmt.byte_rate,
		out_res.fmt.samp_rate,
		out_res.fmt.chan_count,
		out_res.fmt.fmt_code,
		out_res.payload_len,
		out_res.payload_pos,
		out_res.status};

endmodule

>>> hdl/whcp_fmt.sv
// ----------------------------------------------------------------------------
// Format byte store
// Captures the leading bytes of a fmt chunk body and presents its fields.
// ----------------------------------------------------------------------------
module whcp_fmt (
	input  logic                 clk,
	input  logic                 arst_n,
	input  whcp_pkg::fmt_wr_t    wr,
	output whcp_pkg::fmt_fields_t fields
);

	logic [7:0] fmt_q [whcp_pkg::FMT_BYTES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < whcp_pkg::FMT_BYTES; i++) fmt_q[i] <= 8'd0;
		end else if (wr.clr) begin
			for (int i = 0; i < whcp_pkg::FMT_BYTES; i++) fmt_q[i] <= 8'd0;
		end else if (wr.en) begin
			fmt_q[wr.idx] <= wr.data;
		end
	end

	assign fields.fmt_code    = {fmt_q[1], fmt_q[0]};
	assign fields.chan_count  = {fmt_q[3], fmt_q[2]};
	assign fields.samp_rate   = {fmt_q[7], fmt_q[6], fmt_q[5], fmt_q[4]};
	assign fields.byte_rate   = {fmt_q[11], fmt_q[10], fmt_q[9], fmt_q[8]};
	assign fields.block_align = {fmt_q[13], fmt_q[12]};
	assign fields.samp_bits   = {fmt_q[15], fmt_q[14]};

endmodule

>>> hdl/whcp_core.sv
// ----------------------------------------------------------------------------
// Header parse core
// Per-byte state update for the RIFF header and chunk walk; forms the result.
// ----------------------------------------------------------------------------
module whcp_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  take,
	input  logic [7:0]            byte_value,
	input  logic                  last_byte,
	input  whcp_pkg::fmt_fields_t fmt,
	output logic                  res_valid,
	output whcp_pkg::res_t        res,
	output whcp_pkg::fmt_wr_t     fmt_wr
);

	whcp_pkg::phase_t phase_q, phase_d;
	logic [31:0] pos_q;
	logic [3:0]  cnt_q;
	logic        mis_q;
	logic [31:0] tag_q;
	logic [31:0] len_q;
	logic [31:0] rem_q;
	logic [whcp_pkg::FMT_CNT_W-1:0] fidx_q;

	logic [31:0] pos_d;
	logic [31:0] len_full;
	logic [2:0]  k;
	logic        cur_mis;
	logic        riff_end;
	logic        hdr_end;
	logic        body_end;
	logic        is_data;
	logic        emit_riff;
	logic        emit_data;
	logic        fmt_room;
	logic        fmt_ok;

	always_comb begin
		pos_d    = pos_q + 32'd1;
		len_full = {byte_value, len_q[31:8]};
		k        = cnt_q[2:0];
		cur_mis  = ((cnt_q < 4'd4) && (byte_value != whcp_pkg::riff_char(cnt_q[1:0]))) ||
			((cnt_q >= 4'd8) && (cnt_q < 4'd12) &&
			(byte_value != whcp_pkg::wave_char(cnt_q[1:0])));
		riff_end = (cnt_q == 4'd11);
		hdr_end  = (k == 3'd7);
		body_end = (rem_q == 32'd1);
		is_data  = (tag_q == whcp_pkg::TAG_DATA);
		fmt_room = (fidx_q < whcp_pkg::FMT_CNT_W'(whcp_pkg::FMT_BYTES));
	end

	// next state
	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			whcp_pkg::PH_RIFF: begin
				if (riff_end)
					phase_d = (mis_q | cur_mis) ? whcp_pkg::PH_DONE : whcp_pkg::PH_CHUNK_HDR;
			end
			whcp_pkg::PH_CHUNK_HDR: begin
				if (hdr_end) begin
					if (is_data)
						phase_d = whcp_pkg::PH_DONE;
					else if (len_full != 32'd0)
						phase_d = whcp_pkg::PH_BODY;
					else
						phase_d = whcp_pkg::PH_CHUNK_HDR;
				end
			end
			whcp_pkg::PH_BODY: begin
				if (body_end)
					phase_d = len_q[0] ? whcp_pkg::PH_PAD : whcp_pkg::PH_CHUNK_HDR;
			end
			whcp_pkg::PH_PAD: phase_d = whcp_pkg::PH_CHUNK_HDR;
			whcp_pkg::PH_DONE: phase_d = whcp_pkg::PH_DONE;
			default: phase_d = whcp_pkg::PH_RIFF;
		endcase
		if (last_byte)
			phase_d = whcp_pkg::PH_RIFF;
	end

	// outputs
	always_comb begin
		emit_riff = (phase_q == whcp_pkg::PH_RIFF) && riff_end && (mis_q | cur_mis);
		emit_data = (phase_q == whcp_pkg::PH_CHUNK_HDR) && hdr_end && is_data;
		res_valid = take && (emit_riff || emit_data ||
			(last_byte && (phase_q != whcp_pkg::PH_DONE)));
		fmt_ok    = (fmt.fmt_code == 16'd1) && (fmt.samp_bits == 16'd16) &&
			((fmt.chan_count == 16'd1) || (fmt.chan_count == 16'd2));

		res        = '0;
		res.status = whcp_pkg::ST_INVALID;
		if (emit_data && (len_full != 32'd0)) begin
			res.status      = fmt_ok ? whcp_pkg::ST_OK : whcp_pkg::ST_UNSUPPORTED;
			res.payload_pos = pos_d;
			res.payload_len = len_full;
			res.fmt         = fmt;
		end

		fmt_wr.en   = take && !last_byte && (phase_q == whcp_pkg::PH_BODY) &&
			(tag_q == whcp_pkg::TAG_FMT) && fmt_room;
		fmt_wr.clr  = take && last_byte;
		fmt_wr.idx  = fidx_q[whcp_pkg::FMT_IDX_W-1:0];
		fmt_wr.data = byte_value;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= whcp_pkg::PH_RIFF;
		end else if (take) begin
			phase_q <= phase_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= 32'd0;
			cnt_q  <= 4'd0;
			mis_q  <= 1'b0;
			tag_q  <= 32'd0;
			len_q  <= 32'd0;
			rem_q  <= 32'd0;
			fidx_q <= '0;
		end else if (take) begin
			if (last_byte) begin
				pos_q  <= 32'd0;
				cnt_q  <= 4'd0;
				mis_q  <= 1'b0;
				tag_q  <= 32'd0;
				len_q  <= 32'd0;
				rem_q  <= 32'd0;
				fidx_q <= '0;
			end else begin
				pos_q <= pos_d;
				case (phase_q)
					whcp_pkg::PH_RIFF: begin
						mis_q <= mis_q | cur_mis;
						cnt_q <= riff_end ? 4'd0 : cnt_q + 4'd1;
					end
					whcp_pkg::PH_CHUNK_HDR: begin
						if (k < 3'd4)
							tag_q <= {byte_value, tag_q[31:8]};
						else
							len_q <= len_full;
						cnt_q <= hdr_end ? 4'd0 : {1'b0, k} + 4'd1;
						if (hdr_end) begin
							rem_q  <= len_full;
							fidx_q <= '0;
						end
					end
					whcp_pkg::PH_BODY: begin
						rem_q <= rem_q - 32'd1;
						if (fmt_wr.en)
							fidx_q <= fidx_q + whcp_pkg::FMT_CNT_W'(1);
					end
					default: begin
					end
				endcase
			end
		end
	end

endmodule

>>> hdl/whcp_skid.sv
// ----------------------------------------------------------------------------
// Result output stage
// Output register with one skid entry so requests keep flowing under stall.
// ----------------------------------------------------------------------------
module whcp_skid (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  whcp_pkg::res_t push_data,
	output logic           push_ready,
	output logic           out_valid,
	input  logic           out_ready,
	output whcp_pkg::res_t out_data
);

	logic           out_v_q;
	logic           skid_v_q;
	whcp_pkg::res_t out_q;
	whcp_pkg::res_t skid_q;
	logic           slot_free;

	assign push_ready = !skid_v_q;
	assign out_valid  = out_v_q;
	assign out_data   = out_q;
	assign slot_free  = !out_v_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (slot_free) begin
			out_v_q  <= skid_v_q | push;
			skid_v_q <= 1'b0;
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (slot_free) begin
			out_q <= skid_v_q ? skid_q : push_data;
		end else if (push) begin
			skid_q <= push_data;
		end
	end

endmodule

>>> hdl/whcp_checker.sv
// ----------------------------------------------------------------------------
// WAV header chunk parser checker
// Port-level properties of the result stream and input ready, bound to the top level.
// ----------------------------------------------------------------------------
module whcp_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_axis_tready,
	input logic                              m_axis_tvalid,
	input logic                              m_axis_tready,
	input logic [whcp_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result request changed under stall");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[1:0] != 2'd3)
		else $error("undefined status code");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[1:0] == whcp_pkg::ST_INVALID) |->
		m_axis_tdata[whcp_pkg::OUT_TDATA_W-1:2] == '0)
		else $error("invalid result carries field data");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid)
		else $error("input stalled with no result pending");

endmodule

bind wav_header_chunk_parser whcp_checker u_whcp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
